// File: src/occ_pkg.sv
// Shared types and constants for the optimal cut cost interval solver.
// Used by every module in src; depends on nothing.
package occ_pkg;

    localparam int POS_BITS  = 16;
    localparam int COST_BITS = 24;
    // a + b + 2*len stays below 2^(COST_BITS+2)
    localparam int SUM_BITS  = COST_BITS + 2;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    typedef struct packed {
        logic [POS_BITS-1:0] point_position;
        logic                last_point;
    } t_in_word;

    typedef struct packed {
        logic [COST_BITS-1:0] min_effort;
        logic                 too_many_points;
        logic                 saturated;
    } t_out_word;

    // control that travels with one pair of table reads into the span unit
    typedef struct packed {
        logic start;
        logic rd_v;
        logic first;
        logic last;
    } t_span_ctl;

endpackage

// File: src/occ_point_store.sv
// Point position store: one write port, two registered read ports.
// Depends on occ_pkg.
module occ_point_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [occ_pkg::POS_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr_a,
    input  logic [AW-1:0]                i_raddr_b,
    output logic [occ_pkg::POS_BITS-1:0] o_rdata_a,
    output logic [occ_pkg::POS_BITS-1:0] o_rdata_b
);

    logic [occ_pkg::POS_BITS-1:0] r_mem [DEPTH];
    logic [occ_pkg::POS_BITS-1:0] r_rd_a;
    logic [occ_pkg::POS_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// File: src/occ_cost_table.sv
// Span cost table: one write port, two registered read ports.
// Depends on occ_pkg.
module occ_cost_table #(
    parameter int AW = 12
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [occ_pkg::COST_BITS-1:0] i_wdata,
    input  logic [AW-1:0]                 i_raddr_a,
    input  logic [AW-1:0]                 i_raddr_b,
    output logic [occ_pkg::COST_BITS-1:0] o_rdata_a,
    output logic [occ_pkg::COST_BITS-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [occ_pkg::COST_BITS-1:0] r_mem [DEPTH];
    logic [occ_pkg::COST_BITS-1:0] r_rd_a;
    logic [occ_pkg::COST_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// File: src/occ_span_unit.sv
// Shared add/compare unit: sums one split candidate and keeps the running minimum.
// Depends on occ_pkg.
module occ_span_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  occ_pkg::t_span_ctl            i_ctl,
    input  logic [occ_pkg::COST_BITS-1:0] i_rd_a,
    input  logic [occ_pkg::COST_BITS-1:0] i_rd_b,
    input  logic [occ_pkg::POS_BITS:0]    i_len2,
    output logic [occ_pkg::SUM_BITS-1:0]  o_best,
    output logic                          o_busy
);

    logic [occ_pkg::COST_BITS-1:0] w_a;
    logic [occ_pkg::COST_BITS-1:0] w_b;
    logic [occ_pkg::SUM_BITS-1:0]  r_sum;
    logic [occ_pkg::SUM_BITS-1:0]  r_best;
    logic                          r_s2;

    // neighbor spans cost nothing and are never written
    assign w_a = i_ctl.first ? '0 : i_rd_a;
    assign w_b = i_ctl.last  ? '0 : i_rd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2 <= 1'b0;
        end else begin
            r_s2 <= i_ctl.rd_v;
        end
        r_sum <= occ_pkg::SUM_BITS'(w_a) + occ_pkg::SUM_BITS'(w_b)
               + occ_pkg::SUM_BITS'(i_len2);
        if (i_ctl.start) begin
            r_best <= occ_pkg::SUM_BITS'(occ_pkg::COST_MAX);
        end else if (r_s2 && (r_sum < r_best)) begin
            r_best <= r_sum;
        end
    end

    assign o_best = r_best;
    assign o_busy = r_s2;

endmodule

// File: src/optimal_cut_cost_interval_dp.sv
// Optimal cut cost solver: loads points, then fills the span cost table by diagonals.
// Loading accepts one point word per cycle until the last point. After it, each span (i, j)
// with d = j - i is reduced over its split points on the shared add/compare unit, and the
// result word appears in the cycle after the last span is written; under three points give 0.
// One list is in flight at a time; input stalls from the last point until the result is taken.
// Synchronous active-low reset clears control state only; the point and cost stores are not cleared.
module optimal_cut_cost_interval_dp #(
    parameter int MAX_POINTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  occ_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output occ_pkg::t_out_word o_out_word
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = IW + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_SPAN, S_LEN, S_LOOP, S_WR, S_OUT
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_count;
    logic                           r_ovf;
    logic [IW-1:0]                  r_i;
    logic [IW-1:0]                  r_d;
    logic [IW-1:0]                  r_k;
    logic [occ_pkg::POS_BITS:0]     r_len2;
    occ_pkg::t_span_ctl             r_ctl;
    occ_pkg::t_span_ctl             n_ctl;
    occ_pkg::t_out_word             r_out;

    logic                           w_accept;
    logic                           w_room;
    logic [CW-1:0]                  w_count_new;
    logic                           w_ovf_new;
    logic [IW-1:0]                  w_j;
    logic [occ_pkg::POS_BITS-1:0]   w_pi;
    logic [occ_pkg::POS_BITS-1:0]   w_pj;
    logic [occ_pkg::COST_BITS-1:0]  w_ta;
    logic [occ_pkg::COST_BITS-1:0]  w_tb;
    logic [occ_pkg::SUM_BITS-1:0]   w_best;
    logic                           w_busy;
    logic                           w_loop_done;
    logic                           w_issue;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_room      = r_count < CW'(MAX_POINTS);
    assign w_count_new = w_room ? r_count + CW'(1) : r_count;
    assign w_ovf_new   = r_ovf || !w_room;
    assign w_j         = r_i + r_d;
    assign w_loop_done = (r_k == w_j) && !r_ctl.rd_v && !w_busy;
    assign w_issue     = (r_state == S_LOOP) && (r_k != w_j);

    // control for the split read issued this cycle
    always_comb begin
        n_ctl       = '0;
        n_ctl.start = (r_state == S_LEN);
        n_ctl.rd_v  = w_issue;
        n_ctl.first = w_issue && (r_k == r_i + IW'(1));
        n_ctl.last  = w_issue && (r_k == w_j - IW'(1));
    end

    occ_point_store #(
        .DEPTH (MAX_POINTS),
        .AW    (IW)
    ) u_points (
        .i_clk     (i_clk),
        .i_we      (w_accept && w_room),
        .i_waddr   (r_count[IW-1:0]),
        .i_wdata   (i_in_word.point_position),
        .i_raddr_a (r_i),
        .i_raddr_b (w_j),
        .o_rdata_a (w_pi),
        .o_rdata_b (w_pj)
    );

    occ_cost_table #(
        .AW (2 * IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (r_state == S_WR),
        .i_waddr   ({r_i, w_j}),
        .i_wdata   (w_best[occ_pkg::COST_BITS-1:0]),
        .i_raddr_a ({r_i, r_k}),
        .i_raddr_b ({r_k, w_j}),
        .o_rdata_a (w_ta),
        .o_rdata_b (w_tb)
    );

    occ_span_unit u_span (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_ctl),
        .i_rd_a  (w_ta),
        .i_rd_b  (w_tb),
        .i_len2  (r_len2),
        .o_best  (w_best),
        .o_busy  (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_ctl   <= '0;
        end else begin
            r_ctl <= n_ctl;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_count <= w_count_new;
                        r_ovf   <= w_ovf_new;
                        if (i_in_word.last_point) begin
                            r_out.too_many_points <= w_ovf_new;
                            r_out.min_effort      <= '0;
                            r_out.saturated       <= 1'b0;
                            r_i                   <= '0;
                            r_d                   <= IW'(2);
                            if (SW'(w_count_new) < SW'(3)) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SPAN;
                            end
                        end
                    end
                end
                S_SPAN: begin
                    r_state <= S_LEN;
                end
                S_LEN: begin
                    // descending positions give a zero-length span
                    r_len2    <= (w_pj >= w_pi) ? {w_pj - w_pi, 1'b0} : '0;
                    r_k       <= r_i + IW'(1);
                    r_state   <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_k != w_j) begin
                        r_k <= r_k + IW'(1);
                    end else if (w_loop_done) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (SW'(r_i) + SW'(r_d) + SW'(1) < SW'(r_count)) begin
                        r_i     <= r_i + IW'(1);
                        r_state <= S_SPAN;
                    end else if (SW'(r_d) + SW'(1) < SW'(r_count)) begin
                        r_d     <= r_d + IW'(1);
                        r_i     <= '0;
                        r_state <= S_SPAN;
                    end else begin
                        r_out.min_effort <= w_best[occ_pkg::COST_BITS-1:0];
                        r_out.saturated  <=
                            (w_best == occ_pkg::SUM_BITS'(occ_pkg::COST_MAX));
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_out_word  = r_out;

    a_no_load_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result word is pending");

    a_best_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (w_best <= occ_pkg::SUM_BITS'(occ_pkg::COST_MAX)))
        else $error("span cost above clamp value");

    a_sat_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.saturated) |->
            (o_out_word.min_effort == occ_pkg::COST_MAX))
        else $error("saturated flag without maximum effort");

    a_split_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> ((r_k > r_i) && (r_k <= w_j)))
        else $error("split index outside its span");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond store size");

endmodule
